/* hw/rtl/slse_pkg.sv */
package slse_pkg;

	localparam int FIELD_FRAC_BITS = 16;
	localparam int EXP_TABLE_BITS  = 8;

	localparam int TAB_N         = 1 << EXP_TABLE_BITS;
	localparam int EXP_REM_BITS  = 32 - EXP_TABLE_BITS;
	localparam int DEN_SHIFT     = 30 - FIELD_FRAC_BITS;
	localparam int DEN_W         = 31 + DEN_SHIFT;
	localparam int FDIV_STEPS    = 30;
	localparam int SDIV_STEPS    = 32;

	localparam logic [31:0] K_GAUSS   = 32'd2528468765;
	localparam logic [31:0] K_LORENTZ = 32'd3719550771;
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;

	// 2^(-x) table, Q1.30, one extra entry for interpolation at the top
	typedef logic [30:0] exp_rom_t [TAB_N+1];

	function automatic exp_rom_t exp_rom_build();
		exp_rom_t rom;
		logic [63:0] xq;
		logic [63:0] y;
		logic [63:0] sum;
		logic [63:0] term;
		for (int k = 0; k <= TAB_N; k++) begin
			xq = 64'(k) << (30 - EXP_TABLE_BITS);
			y = (xq * 64'(LN2_Q32)) >> 32;
			sum = 64'd1 << 30;
			term = 64'd1 << 30;
			for (int n = 1; n <= 13; n++) begin
				term = ((term * y) >> 30) / 64'(n);
				if ((n % 2) == 1) sum = sum - term;
				else sum = sum + term;
			end
			rom[k] = 31'(sum);
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = exp_rom_build();

	typedef struct packed {
		logic        deriv;
		logic        lor;
		logic        tail;
		logic        neg;
		logic        zero;
		logic [31:0] amag;
		logic [30:0] h;
	} side_t;

	typedef struct packed {
		logic        deriv;
		logic        neg;
		logic        zero;
		logic [32:0] mag_abs;
	} fin_side_t;

endpackage

/* hw/rtl/slse_front.sv */
module slse_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic                 action,
	input  logic signed [31:0]   amplitude,
	input  logic [30:0]          line_width,
	input  logic signed [31:0]   line_center,
	input  logic signed [31:0]   eval_field,
	input  logic                 deriv,
	output logic                 out_valid,
	output logic [32:0]          out_xa,
	output logic [32:0]          out_xb,
	output logic [36:0]          out_d,
	output slse_pkg::side_t      out_side
);
	import slse_pkg::*;

	// s1: offset, magnitudes, scaled width
	logic        v_s1, lor_s1, amp_neg_s1, d_neg_s1, deriv_s1;
	logic [31:0] amag_s1;
	logic [32:0] dmag_s1;
	logic [30:0] h_s1;

	logic [32:0] dv;
	logic [63:0] hprod;

	always_comb begin
		dv = {eval_field[31], eval_field} - {line_center[31], line_center};
		hprod = 64'(line_width) * 64'(action ? K_LORENTZ : K_GAUSS) + 64'h8000_0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lor_s1 <= action;
			deriv_s1 <= deriv;
			amp_neg_s1 <= amplitude[31];
			amag_s1 <= amplitude[31] ? 32'(-amplitude) : 32'(amplitude);
			d_neg_s1 <= dv[32];
			dmag_s1 <= dv[32] ? 33'(-dv) : dv;
			h_s1 <= hprod[62:32];
		end
	end

	// s2: squares and cross product
	logic        v_s2;
	logic [61:0] a2_s2, b2_s2, ab_s2;
	logic [32:0] dmag_s2;
	side_t       side_s2;

	logic        big;
	logic [30:0] a_op, b_op;

	always_comb begin
		big = dmag_s1[32] | dmag_s1[31];
		a_op = big ? (h_s1 >> 1) : h_s1;
		b_op = big ? dmag_s1[31:1] : dmag_s1[30:0];
	end

	// s3: sum of squares
	logic        v_s3;
	logic [62:0] s_s3;
	logic [61:0] a2_s3, ab_s3;
	logic [32:0] dmag_s3;
	side_t       side_s3;

	// s4: shift that brings the sum into 32 bits
	logic        v_s4;
	logic [62:0] s_s4;
	logic [61:0] a2_s4, ab_s4;
	logic [32:0] dmag_s4;
	logic [4:0]  t_s4;
	side_t       side_s4;

	logic [4:0] t_c;

	always_comb begin
		t_c = 5'd0;
		for (int i = 32; i <= 62; i++) begin
			if (s_s3[i]) t_c = 5'(i - 31);
		end
	end

	// s5: divider operands
	logic        v_s5;
	logic [32:0] xa_s5, xb_s5;
	logic [36:0] d_s5;
	side_t       side_s5;

	logic [31:0] st, a2t, abt;

	always_comb begin
		st = 32'(s_s4 >> t_s4);
		a2t = 32'(a2_s4 >> t_s4);
		abt = 32'(ab_s4 >> t_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a2_s2 <= 62'(a_op) * 62'(a_op);
			b2_s2 <= 62'(b_op) * 62'(b_op);
			ab_s2 <= 62'(a_op) * 62'(b_op);
			dmag_s2 <= dmag_s1;
			side_s2.deriv <= deriv_s1;
			side_s2.lor <= lor_s1;
			side_s2.tail <= dmag_s1 >= {h_s1, 3'b000};
			side_s2.neg <= deriv_s1 ? (amp_neg_s1 ^ d_neg_s1) : amp_neg_s1;
			side_s2.zero <= (h_s1 == 31'd0) || (deriv_s1 && (dmag_s1 == 33'd0));
			side_s2.amag <= amag_s1;
			side_s2.h <= h_s1;

			s_s3 <= 63'(a2_s2) + 63'(b2_s2);
			a2_s3 <= a2_s2;
			ab_s3 <= ab_s2;
			dmag_s3 <= dmag_s2;
			side_s3 <= side_s2;

			s_s4 <= s_s3;
			a2_s4 <= a2_s3;
			ab_s4 <= ab_s3;
			dmag_s4 <= dmag_s3;
			t_s4 <= t_c;
			side_s4 <= side_s3;

			// Gaussian: u = dmag*2^24/h = dmag*2^30/(h*2^6)
			xa_s5 <= side_s4.lor ? {1'b0, a2t} : dmag_s4;
			xb_s5 <= {1'b0, abt};
			d_s5 <= side_s4.lor ? {5'd0, st} : {side_s4.h, 6'd0};
			side_s5 <= side_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_xa = xa_s5;
	assign out_xb = xb_s5;
	assign out_d = d_s5;
	assign out_side = side_s5;

endmodule

/* hw/rtl/slse_frac_div.sv */
module slse_frac_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [32:0]     in_xa,
	input  logic [32:0]     in_xb,
	input  logic [36:0]     in_d,
	input  slse_pkg::side_t in_side,
	output logic            out_valid,
	output logic [30:0]     out_qa,
	output logic [30:0]     out_qb,
	output slse_pkg::side_t out_side
);
	import slse_pkg::*;

	// Two lanes of floor(x*2^30/d) sharing one divisor, one quotient bit per stage.
	typedef struct packed {
		logic [36:0] rem;
		logic [30:0] quo;
	} lane_t;

	function automatic lane_t pre_step(logic [32:0] x, logic [36:0] d);
		lane_t l;
		logic  ge;
		ge = {4'd0, x} >= d;
		l.rem = ge ? 37'({4'd0, x} - d) : {4'd0, x};
		l.quo = {30'd0, ge};
		return l;
	endfunction

	function automatic lane_t div_step(lane_t l, logic [36:0] d);
		lane_t       o;
		logic [37:0] r2;
		r2 = {l.rem, 1'b0};
		if (r2 >= {1'b0, d}) begin
			o.rem = 37'(r2 - {1'b0, d});
			o.quo = {l.quo[29:0], 1'b1};
		end else begin
			o.rem = r2[36:0];
			o.quo = {l.quo[29:0], 1'b0};
		end
		return o;
	endfunction

	logic  v_s    [FDIV_STEPS+1];
	lane_t la_s   [FDIV_STEPS+1];
	lane_t lb_s   [FDIV_STEPS+1];
	logic [36:0] d_s [FDIV_STEPS+1];
	side_t side_s [FDIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= FDIV_STEPS; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i <= FDIV_STEPS; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			la_s[0] <= pre_step(in_xa, in_d);
			lb_s[0] <= pre_step(in_xb, in_d);
			d_s[0] <= in_d;
			side_s[0] <= in_side;
			for (int i = 1; i <= FDIV_STEPS; i++) begin
				la_s[i] <= div_step(la_s[i-1], d_s[i-1]);
				lb_s[i] <= div_step(lb_s[i-1], d_s[i-1]);
				d_s[i] <= d_s[i-1];
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign out_valid = v_s[FDIV_STEPS];
	assign out_qa = la_s[FDIV_STEPS].quo;
	assign out_qb = lb_s[FDIV_STEPS].quo;
	assign out_side = side_s[FDIV_STEPS];

endmodule

/* hw/rtl/slse_shape.sv */
module slse_shape (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [30:0]                 in_qa,
	input  logic [30:0]                 in_qb,
	input  slse_pkg::side_t             in_side,
	output logic                        out_valid,
	output logic [66:0]                 out_n,
	output logic [slse_pkg::DEN_W-1:0]  out_den,
	output slse_pkg::fin_side_t         out_side
);
	import slse_pkg::*;

	// s1: u^2 for the Gaussian, r*w for the Lorentzian derivative
	logic        v_s1;
	logic [26:0] u_s1;
	logic [30:0] r_s1;
	logic [37:0] e_s1;
	logic [31:0] lp_s1;
	side_t       side_s1;

	logic [53:0] uu;
	logic [61:0] rw;

	always_comb begin
		uu = 54'(in_qa[26:0]) * 54'(in_qa[26:0]);
		rw = 62'(in_qa) * 62'(in_qb) + 62'(64'd1 << 28);
	end

	// s2: table lookup
	logic        v_s2;
	logic [26:0] u_s2;
	logic [30:0] r_s2, t0_s2, t1_s2;
	logic [5:0]  ip_s2;
	logic [EXP_REM_BITS-1:0] frem_s2;
	logic [31:0] lp_s2;
	side_t       side_s2;

	logic [EXP_TABLE_BITS:0] idx0, idx1;

	always_comb begin
		idx0 = {1'b0, e_s1[31:EXP_REM_BITS]};
		idx1 = idx0 + (EXP_TABLE_BITS+1)'(1);
	end

	// s3: interpolation and integer-part shift
	logic        v_s3;
	logic [26:0] u_s3;
	logic [30:0] r_s3, g_s3;
	logic [31:0] lp_s3;
	side_t       side_s3;

	logic [30:0] tdiff, m_c;
	logic [31+EXP_REM_BITS-1:0] iprod;

	always_comb begin
		tdiff = t0_s2 - t1_s2;
		iprod = (31+EXP_REM_BITS)'(tdiff) * (31+EXP_REM_BITS)'(frem_s2);
		m_c = t0_s2 - 31'(iprod >> EXP_REM_BITS);
	end

	// s4: absorption product, Gaussian u*g
	logic        v_s4;
	logic [32:0] mag_s4, ug_s4;
	logic [31:0] lp_s4;
	side_t       side_s4;

	logic [30:0] sel;
	logic [62:0] absp;
	logic [57:0] ugp;

	always_comb begin
		if (side_s3.lor) sel = r_s3;
		else if (side_s3.tail) sel = 31'd0;
		else sel = g_s3;
		absp = 63'(side_s3.amag) * 63'(sel) + 63'(64'd1 << 29);
		ugp = 58'(u_s3) * 58'(g_s3);
	end

	// s5: derivative factor
	logic        v_s5;
	logic [33:0] p_s5;
	logic [32:0] mag_s5;
	side_t       side_s5;

	logic [65:0] pgp;

	always_comb begin
		pgp = 66'(ug_s4) * 66'(LN2_Q32) + 66'(64'd1 << 30);
	end

	// s6: amplitude times factor, rounding offset
	logic            v_s6;
	logic [66:0]     n_s6;
	logic [DEN_W-1:0] den_s6;
	fin_side_t       fside_s6;

	logic [65:0] num;

	always_comb begin
		num = 66'(side_s5.amag) * 66'(p_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= in_qa[26:0];
			r_s1 <= in_qa;
			e_s1 <= uu[53:16];
			lp_s1 <= rw[60:29];
			side_s1 <= in_side;

			u_s2 <= u_s1;
			r_s2 <= r_s1;
			t0_s2 <= EXP_ROM[idx0];
			t1_s2 <= EXP_ROM[idx1];
			ip_s2 <= e_s1[37:32];
			frem_s2 <= e_s1[EXP_REM_BITS-1:0];
			lp_s2 <= lp_s1;
			side_s2 <= side_s1;

			u_s3 <= u_s2;
			r_s3 <= r_s2;
			g_s3 <= m_c >> ip_s2;
			lp_s3 <= lp_s2;
			side_s3 <= side_s2;

			mag_s4 <= absp[62:30];
			ug_s4 <= side_s3.tail ? 33'd0 : ugp[56:24];
			lp_s4 <= lp_s3;
			side_s4 <= side_s3;

			p_s5 <= side_s4.lor ? {2'b00, lp_s4} : pgp[64:31];
			mag_s5 <= mag_s4;
			side_s5 <= side_s4;

			n_s6 <= 67'(num) + (67'(side_s5.h) << (DEN_SHIFT - 1));
			den_s6 <= DEN_W'(side_s5.h) << DEN_SHIFT;
			fside_s6.deriv <= side_s5.deriv;
			fside_s6.neg <= side_s5.neg;
			fside_s6.zero <= side_s5.zero;
			fside_s6.mag_abs <= mag_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_n = n_s6;
	assign out_den = den_s6;
	assign out_side = fside_s6;

endmodule

/* hw/rtl/slse_scale_div.sv */
module slse_scale_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [66:0]                 in_n,
	input  logic [slse_pkg::DEN_W-1:0]  in_den,
	input  slse_pkg::fin_side_t         in_side,
	output logic                        out_valid,
	output logic [31:0]                 line_value,
	output logic                        saturated
);
	import slse_pkg::*;

	// Long division of n by the field-scaled width, 32 quotient bits plus overflow.
	typedef struct packed {
		logic             over;
		logic [DEN_W-1:0] rem;
		logic [31:0]      nlow;
		logic [31:0]      quo;
	} sdiv_t;

	function automatic sdiv_t sdiv_step(sdiv_t l, logic [DEN_W-1:0] den);
		sdiv_t          o;
		logic [DEN_W:0] r2;
		r2 = {l.rem, l.nlow[31]};
		o.over = l.over;
		o.nlow = {l.nlow[30:0], 1'b0};
		if (r2 >= {1'b0, den}) begin
			o.rem = DEN_W'(r2 - {1'b0, den});
			o.quo = {l.quo[30:0], 1'b1};
		end else begin
			o.rem = r2[DEN_W-1:0];
			o.quo = {l.quo[30:0], 1'b0};
		end
		return o;
	endfunction

	logic             v_s   [SDIV_STEPS+1];
	sdiv_t            dv_s  [SDIV_STEPS+1];
	logic [DEN_W-1:0] den_s [SDIV_STEPS+1];
	fin_side_t        side_s[SDIV_STEPS+1];

	logic             v_fin_s;
	logic [31:0]      value_fin_s;
	logic             sat_fin_s;

	sdiv_t            pre;
	logic [32:0]      magx;
	logic             big, sat_pos, sat_neg;
	logic [31:0]      value_c;
	fin_side_t        fs;

	always_comb begin
		pre.over = DEN_W'(in_n[66:32]) >= in_den;
		pre.rem = DEN_W'(in_n[66:32]);
		pre.nlow = in_n[31:0];
		pre.quo = 32'd0;

		fs = side_s[SDIV_STEPS];
		big = fs.deriv & dv_s[SDIV_STEPS].over;
		magx = fs.deriv ? {1'b0, dv_s[SDIV_STEPS].quo} : fs.mag_abs;
		sat_pos = !fs.neg && (big || (magx > 33'h0_7FFF_FFFF));
		sat_neg = fs.neg && (big || (magx > 33'h0_8000_0000));
		if (fs.zero) value_c = 32'd0;
		else if (sat_pos) value_c = 32'h7FFF_FFFF;
		else if (sat_neg) value_c = 32'h8000_0000;
		else if (fs.neg) value_c = 32'(-magx);
		else value_c = magx[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= SDIV_STEPS; i++) v_s[i] <= 1'b0;
			v_fin_s <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int i = 1; i <= SDIV_STEPS; i++) v_s[i] <= v_s[i-1];
			v_fin_s <= v_s[SDIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= pre;
			den_s[0] <= in_den;
			side_s[0] <= in_side;
			for (int i = 1; i <= SDIV_STEPS; i++) begin
				dv_s[i] <= sdiv_step(dv_s[i-1], den_s[i-1]);
				den_s[i] <= den_s[i-1];
				side_s[i] <= side_s[i-1];
			end
			value_fin_s <= value_c;
			sat_fin_s <= !fs.zero && (sat_pos || sat_neg);
		end
	end

	assign out_valid = v_fin_s;
	assign line_value = value_fin_s;
	assign saturated = sat_fin_s;

endmodule

/* hw/rtl/spectral_line_shape_evaluator.sv */
// Channel    Dir  Payload (tdata / tuser)
// s_axis     in   tdata: amplitude, line_width, line_center, eval_field; tuser: action
// m_axis     out  tdata: line_value; tuser: saturated
// cfg_wr     in   derivative_mode, written when cfg_wr_en is high
//
// One point per cycle while m_axis is not stalled; the two bit-per-stage dividers
// (31 stages for the width ratios, 34 for the final scaling) and 12 stages of
// multiplies, table lookup and output register make up the pipeline.
// Reset clears all valid bits, including those of the output and skid stages, and derivative_mode.
// A one-entry skid holds a result while m_axis stalls; when it is full the whole
// pipeline and s_axis_tready hold until it drains.
module spectral_line_shape_evaluator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [0:0]    cfg_wr_data,     // derivative_mode
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// [31:0] amplitude, [62:32] line_width, [94:63] line_center,
	// [126:95] eval_field, [127] zero
	input  logic [127:0]  s_axis_tdata,
	input  logic [0:0]    s_axis_tuser,    // [0] action
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [31:0]   m_axis_tdata,    // [31:0] line_value
	output logic [0:0]    m_axis_tuser     // [0] saturated
);
	import slse_pkg::*;

	logic derivative_mode_q;
	logic en;

	logic        f_valid;
	logic [32:0] f_xa, f_xb;
	logic [36:0] f_d;
	side_t       f_side;

	logic        q_valid;
	logic [30:0] q_a, q_b;
	side_t       q_side;

	logic             sh_valid;
	logic [66:0]      sh_n;
	logic [DEN_W-1:0] sh_den;
	fin_side_t        sh_side;

	logic        p_valid;
	logic [31:0] p_value;
	logic        p_sat;

	logic        out_v_q, skid_v_q;
	logic [31:0] out_value_q, skid_value_q;
	logic        out_sat_q, skid_sat_q;

	assign en = !skid_v_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			derivative_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			derivative_mode_q <= cfg_wr_data[0];
		end
	end

	slse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (s_axis_tvalid),
		.action      (s_axis_tuser[0]),
		.amplitude   (s_axis_tdata[31:0]),
		.line_width  (s_axis_tdata[62:32]),
		.line_center (s_axis_tdata[94:63]),
		.eval_field  (s_axis_tdata[126:95]),
		.deriv       (derivative_mode_q),
		.out_valid   (f_valid),
		.out_xa      (f_xa),
		.out_xb      (f_xb),
		.out_d       (f_d),
		.out_side    (f_side)
	);

	slse_frac_div u_frac_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.in_xa     (f_xa),
		.in_xb     (f_xb),
		.in_d      (f_d),
		.in_side   (f_side),
		.out_valid (q_valid),
		.out_qa    (q_a),
		.out_qb    (q_b),
		.out_side  (q_side)
	);

	slse_shape u_shape (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (q_valid),
		.in_qa     (q_a),
		.in_qb     (q_b),
		.in_side   (q_side),
		.out_valid (sh_valid),
		.out_n     (sh_n),
		.out_den   (sh_den),
		.out_side  (sh_side)
	);

	slse_scale_div u_scale_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (sh_valid),
		.in_n       (sh_n),
		.in_den     (sh_den),
		.in_side    (sh_side),
		.out_valid  (p_valid),
		.line_value (p_value),
		.saturated  (p_sat)
	);

	// output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_axis_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= p_valid;
			end
		end else if (p_valid && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_v_q) begin
			if (skid_v_q) begin
				out_value_q <= skid_value_q;
				out_sat_q <= skid_sat_q;
			end else begin
				out_value_q <= p_value;
				out_sat_q <= p_sat;
			end
		end else if (p_valid && en) begin
			skid_value_q <= p_value;
			skid_sat_q <= p_sat;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_value_q;
	assign m_axis_tuser = out_sat_q;

endmodule

/* hw/rtl/slse_chk.sv */
module slse_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed under stall");

	// a clipped value sits at one of the two rails
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			(m_axis_tdata == 32'h7FFF_FFFF) || (m_axis_tdata == 32'h8000_0000))
		else $error("saturated flag without rail value");

	// input backpressure only while a result waits
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// skid drains in one transfer
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && m_axis_tready |=> s_axis_tready)
		else $error("skid did not drain");

endmodule

bind spectral_line_shape_evaluator slse_chk u_slse_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
